// File: sv/tbc_pkg.sv
// Package for the three-band crossover: widths, section map, tap program and types.
// Depends on nothing; used by the controller, datapath and top level.
package tbc_pkg;

   localparam int SampleBitsDef = 24;
   localparam int CoefBitsDef   = 24;
   localparam int NumCoefs      = 29;
   localparam int CoefIdxBits   = 5;
   localparam int AccBits       = 64;

   // Register index on the configuration port.
   localparam logic [0:0] RegCouplingMode = 1'b0;

   // Input op codes.
   localparam logic OpSample   = 1'b0;
   localparam logic OpCoefWrite = 1'b1;

   // Sections, in evaluation order.
   typedef enum logic [2:0] {
      SEC_COUPLING = 3'd0,
      SEC_LOW      = 3'd1,
      SEC_BAND     = 3'd2,
      SEC_HIGH     = 3'd3,
      SEC_ROLLOFF  = 3'd4
   } sec_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_START = 3'd1,
      ST_TAP   = 3'd2,
      ST_WAIT  = 3'd3,
      ST_DONE  = 3'd4,
      ST_OUT   = 3'd5
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic       load_in;    // capture the request
      logic       write_coef; // store a coefficient
      logic       sec_start;  // clear accumulator, latch section input
      logic       tap;        // issue one multiply-accumulate
      logic       sec_end;    // round, saturate, update history
      logic       bypass;     // produce bypass result
      sec_type    sec;
      logic [3:0] tap_idx;    // tap within section
   } cmd_type;

   function automatic logic [3:0] sec_order(input sec_type s);
      return (s == SEC_BAND) ? 4'd4 : 4'd2;
   endfunction

   function automatic logic [CoefIdxBits-1:0] sec_base(input sec_type s);
      logic [CoefIdxBits-1:0] b;
      unique case (s)
         SEC_COUPLING: b = 5'd0;
         SEC_LOW:      b = 5'd5;
         SEC_BAND:     b = 5'd10;
         SEC_HIGH:     b = 5'd19;
         default:      b = 5'd24;
      endcase
      return b;
   endfunction

endpackage

// File: sv/tbc_ctrl.sv
// Controller for the crossover: sequences the sections and taps of one request.
// Depends on tbc_pkg.
module tbc_ctrl
   import tbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  logic    req_op,
   input  logic    req_active,
   input  logic    coupling_mode,
   input  logic    rsp_taken,
   output logic    req_ready,
   output logic    rsp_valid,
   output cmd_type cmd
);

   state_type  state_ff, state_in;
   sec_type    sec_ff, sec_in;
   logic [3:0] tap_ff, tap_in;
   logic [1:0] wait_ff, wait_in;
   logic [3:0] ntaps;

   assign ntaps = 4'((sec_order(sec_ff) << 1) + 4'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sec_ff   <= SEC_COUPLING;
         tap_ff   <= '0;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sec_ff   <= sec_in;
         tap_ff   <= tap_in;
         wait_ff  <= wait_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sec_in    = sec_ff;
      tap_in    = tap_ff;
      wait_in   = wait_ff;
      cmd       = '0;
      cmd.sec   = sec_ff;
      cmd.tap_idx = tap_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_fire;
            if (req_fire) begin
               if (req_op == OpCoefWrite) begin
                  cmd.write_coef = 1'b1;
               end else if (!req_active) begin
                  cmd.bypass = 1'b1;
                  state_in   = ST_OUT;
               end else begin
                  sec_in   = coupling_mode ? SEC_COUPLING : SEC_LOW;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.sec_start = 1'b1;
            tap_in   = '0;
            state_in = ST_TAP;
         end
         ST_TAP: begin
            cmd.tap = 1'b1;
            tap_in  = tap_ff + 4'd1;
            if (tap_ff == ntaps - 4'd1) begin
               wait_in  = '0;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // drain the two-stage multiply pipeline
            wait_in = wait_ff + 2'd1;
            if (wait_ff == 2'd2) state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.sec_end = 1'b1;
            if (sec_ff == SEC_ROLLOFF) begin
               state_in = ST_OUT;
            end else begin
               sec_in   = sec_type'(sec_ff + 3'd1);
               state_in = ST_START;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_taken) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: sv/tbc_datapath.sv
// Datapath for the crossover: coefficient store, histories and one shared MAC.
// Depends on tbc_pkg.
module tbc_datapath
   import tbc_pkg::*;
#(
   parameter int SAMPLE_BITS = SampleBitsDef,
   parameter int COEF_BITS   = CoefBitsDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   input  logic [CoefIdxBits-1:0]        coef_index,
   input  logic signed [COEF_BITS-1:0]   coef_value,
   output logic signed [SAMPLE_BITS-1:0] low_out,
   output logic signed [SAMPLE_BITS-1:0] band_out,
   output logic signed [SAMPLE_BITS-1:0] high_out
);

   localparam int Frac = COEF_BITS - 4;
   localparam int PBits = SAMPLE_BITS + COEF_BITS;
   localparam logic signed [AccBits-1:0] AccMax = {1'b0, {(AccBits-1){1'b1}}};
   localparam logic signed [AccBits-1:0] AccMin = {1'b1, {(AccBits-1){1'b0}}};
   localparam logic signed [AccBits-1:0] Half = AccBits'(64'sd1 <<< (Frac - 1));
   localparam logic signed [AccBits-1:0] SHi = AccBits'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
   localparam logic signed [AccBits-1:0] SLo = -SHi - 64'sd1;

   // History layout: per section x1..xN then y1..yN; 24 words in all.
   localparam int HistDepth = 24;

   logic signed [COEF_BITS-1:0]   coef_ff [NumCoefs];
   logic signed [SAMPLE_BITS-1:0] hist_ff [HistDepth];
   logic signed [SAMPLE_BITS-1:0] x_ff, xin_ff, hp_ff;
   logic signed [SAMPLE_BITS-1:0] low_ff, band_ff, high_ff;
   logic signed [COEF_BITS-1:0]   mc_ff;
   logic signed [SAMPLE_BITS-1:0] ms_ff;
   logic                          mneg_ff, mv_ff;
   logic signed [PBits-1:0]       prod_ff;
   logic                          pneg_ff, pv_ff;
   logic signed [AccBits-1:0]     acc_ff, acc_in;

   logic [3:0]             ord;
   logic [4:0]             hbase;
   logic [CoefIdxBits-1:0] cidx;
   logic signed [SAMPLE_BITS-1:0] opnd, sec_x, y;
   logic signed [AccBits-1:0] term, rnd, shr;

   assign ord = sec_order(cmd.sec);

   always_comb begin
      unique case (cmd.sec)
         SEC_COUPLING: hbase = 5'd0;
         SEC_LOW:      hbase = 5'd4;
         SEC_BAND:     hbase = 5'd8;
         SEC_HIGH:     hbase = 5'd16;
         default:      hbase = 5'd20;
      endcase
   end

   // Section input: rolloff takes the high-pass output, others the conditioned sample.
   assign sec_x = (cmd.sec == SEC_ROLLOFF) ? hp_ff : x_ff;

   // Tap k: 0 is b0*x0; odd k=2j-1 is b_j*x_j; even k=2j is a_j*y_j.
   always_comb begin
      cidx = sec_base(cmd.sec);
      opnd = xin_ff;
      if (cmd.tap_idx == 4'd0) begin
         cidx = sec_base(cmd.sec);
      end else if (cmd.tap_idx[0]) begin
         cidx = CoefIdxBits'(sec_base(cmd.sec) + 5'((cmd.tap_idx + 4'd1) >> 1));
         opnd = hist_ff[5'(hbase + 5'((cmd.tap_idx - 4'd1) >> 1))];
      end else begin
         cidx = CoefIdxBits'(sec_base(cmd.sec) + 5'(ord) + 5'(cmd.tap_idx >> 1));
         opnd = hist_ff[5'(hbase + 5'(ord) + 5'((cmd.tap_idx >> 1) - 4'd1))];
      end
   end

   always_comb begin
      term = AccBits'(prod_ff);
      if (pneg_ff) term = -term;
      acc_in = acc_ff + term;
      if (!acc_ff[AccBits-1] && !term[AccBits-1] && acc_in[AccBits-1]) acc_in = AccMax;
      if (acc_ff[AccBits-1] && term[AccBits-1] && !acc_in[AccBits-1]) acc_in = AccMin;
   end

   always_comb begin
      rnd = acc_ff + Half;
      if (!acc_ff[AccBits-1] && rnd[AccBits-1]) rnd = AccMax;
      shr = rnd >>> Frac;
      if (shr > SHi)      y = SAMPLE_BITS'(SHi);
      else if (shr < SLo) y = SAMPLE_BITS'(SLo);
      else                y = SAMPLE_BITS'(shr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumCoefs; i++) coef_ff[i] <= '0;
         for (int i = 0; i < HistDepth; i++) hist_ff[i] <= '0;
         mv_ff <= 1'b0;
         pv_ff <= 1'b0;
      end else begin
         mv_ff <= cmd.tap;
         pv_ff <= mv_ff;
         if (cmd.write_coef && coef_index < CoefIdxBits'(NumCoefs))
            coef_ff[coef_index] <= coef_value;
         if (cmd.sec_end) begin
            for (int k = 3; k > 0; k--) begin
               if (4'(k) < ord) begin
                  hist_ff[5'(hbase + 5'(k))] <= hist_ff[5'(hbase + 5'(k - 1))];
                  hist_ff[5'(hbase + 5'(ord) + 5'(k))] <=
                     hist_ff[5'(hbase + 5'(ord) + 5'(k - 1))];
               end
            end
            hist_ff[hbase] <= xin_ff;
            hist_ff[5'(hbase + 5'(ord))] <= y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) x_ff <= sample_in;
      if (cmd.bypass) begin
         low_ff  <= sample_in;
         band_ff <= '0;
         high_ff <= '0;
      end
      if (cmd.sec_start) begin
         xin_ff <= sec_x;
         acc_ff <= '0;
      end else if (pv_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.tap) begin
         mc_ff   <= coef_ff[cidx];
         ms_ff   <= (cmd.tap_idx == 4'd0) ? sec_x : opnd;
         mneg_ff <= (cmd.tap_idx != 4'd0) && !cmd.tap_idx[0];
      end
      prod_ff <= PBits'(mc_ff) * PBits'(ms_ff);
      pneg_ff <= mneg_ff;
      if (cmd.sec_end) begin
         unique case (cmd.sec)
            SEC_COUPLING: x_ff <= y;
            SEC_LOW:      low_ff <= y;
            SEC_BAND:     band_ff <= y;
            SEC_HIGH:     hp_ff <= y;
            default:      high_ff <= y;
         endcase
      end
   end

   assign low_out  = low_ff;
   assign band_out = band_ff;
   assign high_out = high_ff;

endmodule

// File: sv/three_band_iir_crossover.sv
// Top level of the three-band IIR crossover: stream ports, APB register, and
// the controller and datapath. Depends on tbc_pkg, tbc_ctrl and tbc_datapath.
//
// Each audio request yields one response carrying low, band and high outputs.
// The request kind (audio sample or coefficient write) travels on req_tuser.
// Filtering runs on one shared multiply-accumulate unit. Every section is
// opened, issues its taps (2*order+1) one per cycle, drains the two-stage
// multiplier and is then rounded and saved. A bypassed request (active low)
// answers in the cycle after acceptance, and a coefficient write is absorbed
// in its acceptance cycle with no response. One request is worked on at a
// time; the next is taken once the response has been accepted. Coefficients
// (Q4.20) and histories are cleared by reset. The single register,
// coupling_mode at address 0, resets to 1.
module three_band_iir_crossover
   import tbc_pkg::*;
#(
   parameter int SAMPLE_BITS = SampleBitsDef,
   parameter int COEF_BITS   = CoefBitsDef
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // tdata: sample_in, active, coef_index, coef_value (lowest first)
   input  logic [((SAMPLE_BITS + 1 + CoefIdxBits + COEF_BITS + 7) / 8) * 8 - 1:0]
                req_tdata,
   // tuser: op
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata: low_out, band_out, high_out (lowest first)
   output logic [((3*SAMPLE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int OutBits = ((3*SAMPLE_BITS + 7) / 8) * 8;

   logic    coupling_ff;
   logic    req_fire;
   cmd_type cmd;
   logic    req_op, req_active;
   logic signed [SAMPLE_BITS-1:0] sample_in, low_out, band_out, high_out;
   logic [CoefIdxBits-1:0]        coef_index;
   logic signed [COEF_BITS-1:0]   coef_value;

   assign req_op     = req_tuser[0];
   assign sample_in  = req_tdata[SAMPLE_BITS-1:0];
   assign req_active = req_tdata[SAMPLE_BITS];
   assign coef_index = req_tdata[SAMPLE_BITS+CoefIdxBits:SAMPLE_BITS+1];
   assign coef_value = req_tdata[SAMPLE_BITS+CoefIdxBits+COEF_BITS:SAMPLE_BITS+1+CoefIdxBits];
   assign req_fire   = req_tvalid && req_tready;

   // Configuration register: written on the access phase of an APB write.
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         coupling_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[1:0] == {RegCouplingMode, 1'b0}) begin
         coupling_ff <= csr_pwdata[0];
      end
   end
   assign csr_prdata = (csr_paddr == {RegCouplingMode, 1'b0}) ? {31'd0, coupling_ff} : 32'd0;

   tbc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_fire      (req_fire),
      .req_op        (req_op),
      .req_active    (req_active),
      .coupling_mode (coupling_ff),
      .rsp_taken     (rsp_tready),
      .req_ready     (req_tready),
      .rsp_valid     (rsp_tvalid),
      .cmd           (cmd)
   );

   tbc_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sample_in  (sample_in),
      .coef_index (coef_index),
      .coef_value (coef_value),
      .low_out    (low_out),
      .band_out   (band_out),
      .high_out   (high_out)
   );

   assign rsp_tdata = OutBits'({high_out, band_out, low_out});

endmodule

// File: sv/tbc_checker.sv
// Port-level checker for the crossover, bound to the top level.
// Depends on three_band_iir_crossover's port list only.
module tbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        csr_pready
);

   // A request is never taken while a response waits.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request accepted during response");

   // A waiting response holds its data.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // After a response is taken the block is ready again.
   a_ready_after: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> req_tready) else $error("not ready after response");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind three_band_iir_crossover tbc_checker u_tbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

// File: tb/testbench.sv
// Self-checking testbench for the three-band IIR crossover: stream driver, response
// monitor, APB register writes and a transaction-level predictor of the three filter paths.
// Depends on tbc_pkg and three_band_iir_crossover.
module testbench
   import tbc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB        = 24;
   localparam int CB        = 24;
   localparam int ReqBits   = 56;
   localparam int RspBits   = 72;
   localparam int WatchLim  = 5000;
   localparam int DrainWait = 60;

   typedef struct {
      logic                 op;
      logic signed [SB-1:0] sample;
      logic                 active;
      logic [4:0]           idx;
      logic signed [CB-1:0] value;
   } request_type;

   typedef struct {
      logic [SB-1:0] low;
      logic [SB-1:0] band;
      logic [SB-1:0] high;
   } bands_type;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [ReqBits-1:0] req_tdata;
   logic [0:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [RspBits-1:0] rsp_tdata;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   request_type pending[$];
   bands_type   expected_bands[$];
   request_type cur_req;
   int       errors = 0;
   int       quiet  = 0;
   int       idle_cycles = 0;

   // Predictor state: coefficient store, histories per section, coupling switch.
   longint coef_store[NumCoefs];
   longint hist[5][8];
   logic   coupling_on;

   three_band_iir_crossover u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stream fields, lowest bit first: sample_in, active, coef_index, coef_value.
   // The op field travels on tuser.
   function automatic logic [ReqBits-1:0] pack_request(request_type r);
      return {2'b00, r.value, r.idx, r.active, r.sample};
   endfunction

   function automatic longint clamp_sample(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   // One direct-form I section; history holds x1..xN then y1..yN.
   task automatic run_section(input int s, input int base, input int order,
                              input longint x, output longint y);
      longint acc;
      acc = coef_store[base] * x;
      for (int k = 1; k <= order; k++) begin
         acc = acc + coef_store[base + k] * hist[s][k - 1];
         acc = acc - coef_store[base + order + k] * hist[s][order + k - 1];
      end
      acc = (acc + 64'sd524288) >>> (CB - 4);
      y = clamp_sample(acc);
      for (int k = order - 1; k > 0; k--) begin
         hist[s][k] = hist[s][k - 1];
         hist[s][order + k] = hist[s][order + k - 1];
      end
      hist[s][0] = x;
      hist[s][order] = y;
   endtask

   task automatic predict_crossover(input request_type r);
      longint x, lo, bd, hp, hi;
      bands_type b;
      if (r.op == OpCoefWrite) begin
         if (r.idx < NumCoefs) coef_store[r.idx] = longint'(r.value);
         return;
      end
      x = longint'(r.sample);
      if (!r.active) begin
         b.low = r.sample;
         b.band = '0;
         b.high = '0;
      end else begin
         if (coupling_on) run_section(0, 0, 2, x, x);
         run_section(1, 5, 2, x, lo);
         run_section(2, 10, 4, x, bd);
         run_section(3, 19, 2, x, hp);
         run_section(4, 24, 2, hp, hi);
         b.low = lo[SB-1:0];
         b.band = bd[SB-1:0];
         b.high = hi[SB-1:0];
      end
      expected_bands.push_back(b);
   endtask

   task automatic report_mismatch(input string what, input logic [SB-1:0] got,
                                  input logic [SB-1:0] want);
      if (errors < 40)
         $display("mismatch on %s: got %06h, expected %06h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Driver: a request is held until accepted; the predictor sees it on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) predict_crossover(cur_req);
         if (pending.size() > 0 && (quiet || $urandom_range(0, 99) >= 25)) begin
            cur_req    = pending.pop_front();
            req_tdata  <= pack_request(cur_req);
            req_tuser  <= cur_req.op;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: response fields, lowest bit first: low_out, band_out, high_out.
   always @(posedge clock) begin
      bands_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(0, 99) >= 25);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bands.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata[SB-1:0], '0);
            end else begin
               want = expected_bands.pop_front();
               if (rsp_tdata[SB-1:0] !== want.low)
                  report_mismatch("low_out", rsp_tdata[SB-1:0], want.low);
               if (rsp_tdata[2*SB-1:SB] !== want.band)
                  report_mismatch("band_out", rsp_tdata[2*SB-1:SB], want.band);
               if (rsp_tdata[3*SB-1:2*SB] !== want.high)
                  report_mismatch("high_out", rsp_tdata[3*SB-1:2*SB], want.high);
            end
         end
      end
   end

   // Watchdog: consecutive cycles in which neither channel moves a request.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchLim) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic request_type coef_write(int idx, logic signed [CB-1:0] v);
      request_type r;
      r.op = OpCoefWrite;
      r.sample = SB'($urandom);
      r.active = 1'($urandom_range(0, 1));
      r.idx = 5'(idx);
      r.value = v;
      return r;
   endfunction

   function automatic request_type audio(logic signed [SB-1:0] s, logic act);
      request_type r;
      r.op = OpSample;
      r.sample = s;
      r.active = act;
      r.idx = 5'($urandom);
      r.value = CB'($urandom);
      return r;
   endfunction

   // Feedback taps are kept small so the sections stay stable; a wild set uses
   // the whole Q4.20 range.
   function automatic logic signed [CB-1:0] pick_coef(int idx, bit wild);
      int slot, order;
      if (wild) return CB'($urandom);
      if (idx >= 10 && idx <= 18) begin
         slot = idx - 10;
         order = 4;
      end else begin
         slot = (idx < 10) ? idx % 5 : (idx - 19) % 5;
         order = 2;
      end
      if (slot <= order) return CB'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      if (order == 4) return CB'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      if (slot == 3) return CB'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      return CB'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
   endfunction

   function automatic logic signed [SB-1:0] pick_sample();
      case ($urandom_range(0, 3))
         0: return SB'($urandom);
         1: return ($urandom_range(0, 1)) ? 24'sh7fffff : -24'sh800000;
         default: return SB'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   // A well-formed phase loads every coefficient and then streams samples, with
   // some coefficient updates, stray writes and bypassed samples mixed in.
   task automatic queue_phase(input int n, input bit wild);
      int roll;
      for (int i = 0; i < NumCoefs; i++) pending.push_back(coef_write(i, pick_coef(i, wild)));
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8)
            pending.push_back(coef_write($urandom_range(0, NumCoefs - 1),
                                         pick_coef(0, wild)));
         else if (roll < 11)
            pending.push_back(coef_write($urandom_range(0, 31), CB'($urandom)));
         else if (roll < 22)
            pending.push_back(audio(SB'($urandom), 1'b0));
         else
            pending.push_back(audio(pick_sample(), 1'b1));
      end
   endtask

   task automatic wait_idle();
      while (pending.size() > 0 || req_tvalid || expected_bands.size() > 0)
         @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_coupling(input logic mode);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {RegCouplingMode, 1'b0};
      csr_pwdata  <= {31'd0, mode};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      coupling_on = mode;
   endtask

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      coupling_on = 1'b1;
      foreach (coef_store[i]) coef_store[i] = 0;
      foreach (hist[s, k]) hist[s][k] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: all-zero store first, then every fourth coefficient from a tame set,
      // extreme samples, bypass, writes beyond the store and full-scale coefficients.
      pending.push_back(audio(24'sh7fffff, 1'b1));
      pending.push_back(audio(-24'sh800000, 1'b0));
      for (int i = 0; i < NumCoefs; i += 4)
         pending.push_back(coef_write(i, pick_coef(i, 1'b0)));
      pending.push_back(coef_write(28, 24'sh7fffff));
      pending.push_back(coef_write(29, -24'sh800000));
      pending.push_back(coef_write(31, 24'sh7fffff));
      pending.push_back(coef_write(5, -24'sh800000));
      pending.push_back(audio(24'sh7fffff, 1'b1));
      pending.push_back(audio(-24'sh800000, 1'b1));
      pending.push_back(audio(24'sh000000, 1'b1));
      pending.push_back(audio(-24'sh000001, 1'b1));
      pending.push_back(audio(24'sh7fffff, 1'b0));
      pending.push_back(audio(-24'sh800000, 1'b1));
      pending.push_back(coef_write(0, 24'sh7fffff));
      pending.push_back(coef_write(3, -24'sh800000));
      pending.push_back(audio(24'sh7fffff, 1'b1));
      pending.push_back(audio(-24'sh800000, 1'b1));
      wait_idle();

      write_coupling(1'b0);
      queue_phase(280, 1'b0);
      wait_idle();
      write_coupling(1'b1);
      queue_phase(280, 1'b0);
      wait_idle();
      write_coupling(1'b0);
      queue_phase(150, 1'b1);
      wait_idle();
      write_coupling(1'b1);
      quiet = 1;
      queue_phase(200, 1'b0);
      wait_idle();
      quiet = 0;
      queue_phase(120, 1'b1);

      wait_idle();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
